// ----- hdl/tse_pkg.sv -----
// Package: constants and types for the tween slot engine.
package tse_pkg;
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W = 3;
  localparam int FRAC = 16;
  localparam logic signed [47:0] FX_ONE = 48'sd1 <<< FRAC;
  localparam logic signed [47:0] FX_C1 = 48'(((64'd170158 << FRAC) + 64'd50000) / 64'd100000);
  localparam logic signed [47:0] FX_C3 = FX_C1 + FX_ONE;

  typedef enum logic [2:0] {
    MODE_TICK = 3'd0, MODE_CREATE = 3'd1, MODE_RESTART = 3'd2,
    MODE_RETARGET = 3'd3, MODE_FREE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0, KIND_SUMMARY = 2'd1, KIND_ACK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    EASE_LINEAR = 2'd0, EASE_OUT_CUBIC = 2'd1, EASE_INOUT_CUBIC = 2'd2, EASE_OUT_BACK = 2'd3
  } ease_t;
endpackage

// ----- hdl/tween_slot_engine_with_easing.sv -----
// Top level: slot table, serial divider and one shared multiplier sequencer.
// One request is taken when idle; a retarget runs the divider and the multiplier, while create,
// restart and free only answer with an ack. A tick visits every slot, runs both for each active
// slot and ends with the summary; a stalled output adds its wait.
// The restoring divider is skipped when progress is one; the 3 to 7 step easing program runs
// on the shared 34x19 multiplier. Reset clears flags and control.
module tween_slot_engine_with_easing (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tuser: mode[2:0]
  input  logic [2:0]  in_tuser,
  // tdata: slot[2:0], start_value[34:3], end_value[66:35],
  // duration_ms[82:67], ease_kind[84:83], dt_ms[100:85]
  input  logic [103:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tuser: kind[1:0]
  output logic [1:0]  out_tuser,
  // tdata: slot_index[2:0], value[34:3], active_count[38:35]
  output logic [39:0] out_tdata,
  output logic        out_tlast
);
  import tse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DIV, S_MUL, S_OUT, S_SUM, S_ACK, S_WAIT
  } state_t;

  logic signed [31:0] st_r [SLOT_COUNT];
  logic signed [31:0] en_r [SLOT_COUNT];
  logic [15:0] du_r [SLOT_COUNT];
  logic [15:0] el_r [SLOT_COUNT];
  logic [1:0]  ea_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] act_r;

  state_t state_r;
  logic [2:0] mode_r;
  logic [SLOT_W-1:0] slot_r;
  logic signed [31:0] ev_r;
  logic [15:0] dt_r;
  logic [3:0] cnt_r;
  logic [4:0] bit_r;
  logic [31:0] rem_r;
  logic [16:0] quo_r;
  logic signed [47:0] p_r, a_r, b_r, acc_r;
  logic [3:0] step_r;
  logic done_r;
  logic [39:0] obuf_r;
  logic [1:0] okind_r;
  logic olast_r;
  logic ovalid_r;

  // shared multiplier with floor shift; a side takes the wide operand
  logic signed [33:0] ma;
  logic signed [18:0] mb;
  logic signed [52:0] mprod;
  logic signed [47:0] mres;
  assign mprod = ma * mb;
  assign mres = 48'(mprod >>> FRAC);

  // slot operands
  logic [15:0] cur_el, cur_du;
  logic [16:0] el_sum;
  logic signed [47:0] diff;
  assign cur_el = el_r[slot_r];
  assign cur_du = du_r[slot_r];
  assign el_sum = {1'b0, el_r[slot_r]} + {1'b0, dt_r};
  assign diff = 48'(st_r[slot_r]) - 48'(en_r[slot_r]);

  logic [32:0] trial;
  assign trial = {rem_r, 1'b0} - {17'd0, cur_du};

  logic signed [47:0] sat_v;
  always_comb begin
    sat_v = 48'(st_r[slot_r]) + acc_r;
    if (sat_v > 48'sd2147483647) sat_v = 48'sd2147483647;
    else if (sat_v < -48'sd2147483648) sat_v = -48'sd2147483648;
  end

  // one step of the easing / lerp program per cycle
  logic [1:0] ekind;
  assign ekind = (mode_r == MODE_RETARGET) ? EASE_LINEAR : ea_r[slot_r];
  always_comb begin
    ma = a_r[33:0];
    mb = b_r[18:0];
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = obuf_r;
  assign out_tuser = okind_r;
  assign out_tlast = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          mode_r <= in_tuser;
          slot_r <= in_tdata[2:0];
          ev_r <= in_tdata[66:35];
          dt_r <= in_tdata[100:85];
          cnt_r <= '0;
          unique case (in_tuser)
            MODE_TICK: begin
              slot_r <= '0;
              state_r <= S_SCAN;
            end
            MODE_CREATE: begin
              st_r[in_tdata[2:0]] <= in_tdata[34:3];
              en_r[in_tdata[2:0]] <= in_tdata[66:35];
              du_r[in_tdata[2:0]] <= in_tdata[82:67];
              el_r[in_tdata[2:0]] <= '0;
              ea_r[in_tdata[2:0]] <= in_tdata[84:83];
              act_r[in_tdata[2:0]] <= 1'b1;
              state_r <= S_ACK;
            end
            MODE_RESTART: begin
              el_r[in_tdata[2:0]] <= '0;
              act_r[in_tdata[2:0]] <= 1'b1;
              state_r <= S_ACK;
            end
            MODE_RETARGET: begin
              rem_r <= '0;
              quo_r <= '0;
              bit_r <= 5'd16;
              state_r <= S_DIV;
            end
            MODE_FREE: begin
              act_r[in_tdata[2:0]] <= 1'b0;
              state_r <= S_ACK;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_SCAN: begin
          if (act_r[slot_r]) begin
            cnt_r <= cnt_r + 4'd1;
            el_r[slot_r] <= el_sum[16] ? 16'hFFFF : el_sum[15:0];
            rem_r <= '0;
            quo_r <= '0;
            bit_r <= 5'd16;
            state_r <= S_DIV;
          end else if (slot_r == SLOT_W'(SLOT_COUNT - 1)) begin
            state_r <= S_SUM;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
        S_DIV: begin
          // restoring division of elapsed<<16 by duration, one bit a cycle
          if (cur_du == 16'd0 || cur_el >= cur_du) begin
            p_r <= FX_ONE;
            done_r <= 1'b1;
            a_r <= FX_ONE; b_r <= FX_ONE; step_r <= '0;
            state_r <= S_MUL;
          end else begin
            if (!trial[32]) begin
              rem_r <= trial[31:0];
              quo_r <= {quo_r[15:0], 1'b1};
            end else begin
              rem_r <= {rem_r[30:0], 1'b0};
              quo_r <= {quo_r[15:0], 1'b0};
            end
            if (bit_r == 5'd0) begin
              state_r <= S_MUL;
              step_r <= '0;
              done_r <= 1'b0;
              p_r <= 48'({31'd0, quo_r[15:0], !trial[32]});
            end
            bit_r <= bit_r - 5'd1;
            if (bit_r == 5'd16) rem_r <= {16'd0, cur_el};
            if (bit_r == 5'd16) quo_r <= '0;
          end
        end
        S_MUL: begin
          // step 0 sets operands, or the result for linear; later steps use the product
          step_r <= step_r + 4'd1;
          unique case (ekind)
            EASE_LINEAR: begin
              if (step_r == 4'd0) begin
                acc_r <= p_r;
                step_r <= 4'd12;
              end
            end
            EASE_OUT_CUBIC: begin
              unique case (step_r)
                4'd0: begin a_r <= FX_ONE - p_r; b_r <= FX_ONE - p_r; end
                4'd1: begin a_r <= mres; end
                4'd2: begin acc_r <= FX_ONE - mres; step_r <= 4'd12; end
                default: ;
              endcase
            end
            EASE_INOUT_CUBIC: begin
              if (p_r < (FX_ONE >>> 1)) begin
                unique case (step_r)
                  4'd0: begin a_r <= p_r; b_r <= p_r; end
                  4'd1: a_r <= mres;
                  4'd2: begin acc_r <= mres <<< 2; step_r <= 4'd12; end
                  default: ;
                endcase
              end else begin
                unique case (step_r)
                  4'd0: begin a_r <= (FX_ONE - p_r) <<< 1; b_r <= (FX_ONE - p_r) <<< 1; end
                  4'd1: a_r <= mres;
                  4'd2: begin acc_r <= FX_ONE - (mres >>> 1); step_r <= 4'd12; end
                  default: ;
                endcase
              end
            end
            default: begin
              unique case (step_r)
                4'd0: begin a_r <= p_r - FX_ONE; b_r <= p_r - FX_ONE; end
                4'd1: begin b_r <= mres; acc_r <= mres; end   // q^2
                4'd2: begin a_r <= FX_C3; b_r <= mres; end   // q^3
                4'd3: begin acc_r <= FX_ONE + mres; a_r <= FX_C1; b_r <= acc_r; end
                4'd4: begin acc_r <= acc_r + mres; step_r <= 4'd12; end
                default: ;
              endcase
            end
          endcase
          if (step_r == 4'd12) begin
            a_r <= -diff; b_r <= acc_r;
          end
          if (step_r == 4'd13) begin
            acc_r <= mres;
            state_r <= S_OUT;
          end
        end
        S_OUT: if (!ovalid_r) begin
          if (mode_r == MODE_RETARGET) begin
            st_r[slot_r] <= (cur_du != 16'd0 && cur_el < cur_du) ? sat_v[31:0] : en_r[slot_r];
            en_r[slot_r] <= ev_r;
            el_r[slot_r] <= '0;
            act_r[slot_r] <= 1'b1;
            state_r <= S_ACK;
          end else begin
            if (done_r) act_r[slot_r] <= 1'b0;
            ovalid_r <= 1'b1;
            obuf_r <= {1'b0, 4'd0, sat_v[31:0], slot_r};
            okind_r <= KIND_VALUE;
            olast_r <= 1'b0;
            if (slot_r == SLOT_W'(SLOT_COUNT - 1)) state_r <= S_SUM;
            else begin
              slot_r <= slot_r + 1'b1;
              state_r <= S_SCAN;
            end
          end
        end
        S_SUM: if (!ovalid_r) begin
          ovalid_r <= 1'b1;
          obuf_r <= {1'b0, cnt_r, 32'd0, 3'd0};
          okind_r <= KIND_SUMMARY;
          olast_r <= 1'b1;
          state_r <= S_WAIT;
        end
        S_ACK: if (!ovalid_r) begin
          ovalid_r <= 1'b1;
          obuf_r <= {1'b0, 4'd0, 32'd0, slot_r};
          okind_r <= KIND_ACK;
          olast_r <= 1'b1;
          state_r <= S_WAIT;
        end
        S_WAIT: if (!ovalid_r || out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/tse_checker.sv -----
// Checker: port-level properties of the tween slot engine, bound to the top level.
module tse_checker (
  input logic clk, rst_n, in_tvalid, in_tready, out_tvalid, out_tready, out_tlast,
  input logic [2:0] in_tuser,
  input logic [1:0] out_tuser,
  input logic [39:0] out_tdata
);
  import tse_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("out hold");
  // unknown modes are dropped and leave the input ready
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser <= MODE_FREE |=> !in_tready)
    else $error("busy after request");
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SUMMARY |-> out_tlast) else $error("summary last");
  a_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_VALUE |-> !out_tlast) else $error("value not last");
endmodule

bind tween_slot_engine_with_easing tse_checker u_chk (.*);

// ----- verif/tween_slot_engine_with_easing_tb.sv -----
// Testbench for the tween slot engine: directed and random requests checked against a predictor.
module tween_slot_engine_with_easing_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tse_pkg::*;

  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint C1 = ((64'sd170158 << FRAC) + 64'sd50000) / 64'sd100000;
  localparam longint C3 = C1 + ONE;

  typedef struct {
    kind_t kind;
    logic [2:0] slot_index;
    logic signed [31:0] value;
    logic [3:0] active_count;
    logic last;
  } tween_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [2:0] in_tuser = '0;
  logic [103:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [1:0] out_tuser;
  logic [39:0] out_tdata;
  logic out_tlast;

  // request entry: {mode, tdata}
  logic [106:0] request_q[$];
  tween_result_t expected_q[$];
  bit failed = 1'b0;
  int unsigned cyc = 0;
  int unsigned results_seen = 0;

  // predictor copy of the slot table
  logic signed [31:0] p_start[SLOT_COUNT];
  logic signed [31:0] p_end[SLOT_COUNT];
  logic [15:0] p_dur[SLOT_COUNT];
  logic [15:0] p_elapsed[SLOT_COUNT];
  ease_t p_ease[SLOT_COUNT];
  bit p_active[SLOT_COUNT];

  // slots already created, tracked by the stimulus side
  bit created[SLOT_COUNT];

  tween_slot_engine_with_easing u_top (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic longint slot_progress(int s);
    longint d, e;
    d = p_dur[s];
    e = p_elapsed[s];
    if (d == 0 || e >= d) return ONE;
    return (e << FRAC) / d;
  endfunction

  function automatic longint eased(ease_t k, longint p);
    longint u, w, q;
    case (k)
      EASE_LINEAR: return p;
      EASE_OUT_CUBIC: begin
        u = ONE - p;
        return ONE - fx_mul(fx_mul(u, u), u);
      end
      EASE_INOUT_CUBIC: begin
        if (p < ONE / 2) return 4 * fx_mul(fx_mul(p, p), p);
        w = 2 * (ONE - p);
        w = fx_mul(fx_mul(w, w), w);
        return ONE - ((w * (ONE / 2)) >>> FRAC);
      end
      default: begin
        q = p - ONE;
        return ONE + fx_mul(C3, fx_mul(fx_mul(q, q), q)) + fx_mul(C1, fx_mul(q, q));
      end
    endcase
  endfunction

  function automatic logic signed [31:0] interp(longint a, longint b, longint e);
    longint v;
    v = a + (((b - a) * e) >>> FRAC);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic void push_result(kind_t k, int s, logic signed [31:0] v, int cnt, bit l);
    tween_result_t r;
    r.kind = k;
    r.slot_index = s[2:0];
    r.value = v;
    r.active_count = cnt[3:0];
    r.last = l;
    expected_q.push_back(r);
  endfunction

  // apply one accepted request to the slot table and queue its results
  function automatic void predict_request(logic [106:0] d);
    logic [2:0] md;
    int s, cnt, t;
    longint p;
    md = d[106:104];
    s = d[2:0];
    cnt = 0;
    case (md)
      MODE_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (p_active[i]) begin
            cnt++;
            t = p_elapsed[i] + d[100:85];
            p_elapsed[i] = (t > 65535) ? 16'hFFFF : t[15:0];
            p = slot_progress(i);
            if (p >= ONE) begin
              p = ONE;
              p_active[i] = 1'b0;
            end
            push_result(KIND_VALUE, i, interp(p_start[i], p_end[i], eased(p_ease[i], p)), 0, 0);
          end
        end
        push_result(KIND_SUMMARY, 0, 0, cnt, 1);
      end
      MODE_CREATE: begin
        p_start[s] = d[34:3];
        p_end[s] = d[66:35];
        p_dur[s] = d[82:67];
        p_elapsed[s] = '0;
        p_ease[s] = ease_t'(d[84:83]);
        p_active[s] = 1'b1;
        push_result(KIND_ACK, s, 0, 0, 1);
      end
      MODE_RESTART: begin
        p_elapsed[s] = '0;
        p_active[s] = 1'b1;
        push_result(KIND_ACK, s, 0, 0, 1);
      end
      MODE_RETARGET: begin
        if (p_dur[s] > 0 && p_elapsed[s] < p_dur[s])
          p_start[s] = interp(p_start[s], p_end[s], slot_progress(s));
        else
          p_start[s] = p_end[s];
        p_end[s] = d[66:35];
        p_elapsed[s] = '0;
        p_active[s] = 1'b1;
        push_result(KIND_ACK, s, 0, 0, 1);
      end
      MODE_FREE: begin
        p_active[s] = 1'b0;
        push_result(KIND_ACK, s, 0, 0, 1);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [106:0] pack_request(logic [2:0] md, logic [2:0] s,
      logic [31:0] sv, logic [31:0] ev, logic [15:0] dur, logic [1:0] ek, logic [15:0] dt);
    return {md, 3'd0, dt, ek, dur, ev, sv, s};
  endfunction

  function automatic void add_create(int s, logic [31:0] sv, logic [31:0] ev,
      logic [15:0] dur, ease_t ek);
    request_q.push_back(pack_request(MODE_CREATE, 3'(s), sv, ev, dur, ek, 16'($urandom)));
    created[s] = 1'b1;
  endfunction

  function automatic void add_op(mode_t md, int s, logic [31:0] ev);
    request_q.push_back(pack_request(md, 3'(s), $urandom, ev, 16'($urandom), 2'($urandom),
                                     16'($urandom)));
  endfunction

  function automatic void add_tick(logic [15:0] dt);
    request_q.push_back(pack_request(MODE_TICK, 3'($urandom), $urandom, $urandom,
                                     16'($urandom), 2'($urandom), dt));
  endfunction

  function automatic int pick_created();
    int s;
    do s = $urandom_range(SLOT_COUNT - 1); while (!created[s]);
    return s;
  endfunction

  // quiet window: no idling on either side
  function automatic bit idle_now();
    if (cyc >= 3000 && cyc < 8000) return 1'b0;
    return $urandom_range(99) < 18;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_request({in_tuser, in_tdata});
      if (!in_tvalid || in_tready) begin
        if (request_q.size() > 0 && !idle_now()) begin
          {in_tuser, in_tdata} <= request_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off once traffic is flowing
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 1500;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idle_now();
    end
  end

  // monitor
  always @(posedge clk) begin
    tween_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d slot %0d value %0d count %0d last %0b",
                 $time, out_tuser, out_tdata[2:0], $signed(out_tdata[34:3]),
                 out_tdata[38:35], out_tlast);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (out_tuser !== e.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, e.kind, out_tuser);
          failed = 1'b1;
        end
        if (out_tdata[2:0] !== e.slot_index) begin
          $display("%0t: slot_index expected %0d actual %0d", $time, e.slot_index,
                   out_tdata[2:0]);
          failed = 1'b1;
        end
        if (out_tdata[34:3] !== e.value) begin
          $display("%0t: value expected %0d actual %0d", $time, e.value,
                   $signed(out_tdata[34:3]));
          failed = 1'b1;
        end
        if (out_tdata[38:35] !== e.active_count) begin
          $display("%0t: active_count expected %0d actual %0d", $time, e.active_count,
                   out_tdata[38:35]);
          failed = 1'b1;
        end
        if (out_tlast !== e.last) begin
          $display("%0t: last expected %0b actual %0b", $time, e.last, out_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int r, s;
    foreach (p_active[i]) begin
      p_active[i] = 1'b0;
      p_start[i] = '0;
      p_end[i] = '0;
      p_dur[i] = '0;
      p_elapsed[i] = '0;
      p_ease[i] = EASE_LINEAR;
      created[i] = 1'b0;
    end
    // directed part
    add_create(0, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1000, EASE_LINEAR);
    add_create(1, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1000, EASE_OUT_CUBIC);
    add_create(2, 32'h0, 32'h0001_0000, 16'd1000, EASE_INOUT_CUBIC);
    add_create(3, $urandom, $urandom, 16'd1000, EASE_OUT_BACK);
    add_create(4, 32'd5, -32'sd5, 16'd0, EASE_LINEAR);  // zero duration jumps to end
    add_tick(16'd0);
    add_tick(16'd300);
    add_op(MODE_RETARGET, 2, 32'h7FFF_0000);
    add_tick(16'd500);
    add_op(MODE_RESTART, 1, $urandom);
    add_op(MODE_FREE, 0, $urandom);
    add_create(7, 32'hFFFF_0000, 32'h0003_0000, 16'hFFFF, EASE_OUT_BACK);
    add_tick(16'd40000);
    add_tick(16'hFFFF);  // elapsed saturates, everything ends
    add_op(MODE_RETARGET, 3, $urandom);
    add_op(mode_t'(3'd5), 0, $urandom);
    add_op(mode_t'(3'd6), 5, $urandom);
    add_op(mode_t'(3'd7), 7, $urandom);
    add_tick(16'd0);
    add_tick(16'd1);
    // random part
    for (int n = 0; n < 500; n++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        add_create($urandom_range(SLOT_COUNT - 1), $urandom, $urandom,
                   ($urandom_range(9) < 8) ? 16'($urandom_range(3000)) : 16'($urandom),
                   ease_t'($urandom_range(3)));
      end else if (r < 65) begin
        add_tick(($urandom_range(99) < 85) ? 16'($urandom_range(400)) : 16'($urandom));
      end else if (r < 75) begin
        s = pick_created();
        add_op(MODE_RESTART, s, $urandom);
      end else if (r < 85) begin
        s = pick_created();
        add_op(MODE_RETARGET, s, $urandom);
      end else if (r < 95) begin
        add_op(MODE_FREE, $urandom_range(SLOT_COUNT - 1), $urandom);
      end else begin
        add_op(mode_t'($urandom_range(7, 5)), $urandom_range(7), $urandom);
      end
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (request_q.size() > 0 || in_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (!failed && expected_q.size() == 0)
      $display("tween_slot_engine_with_easing_tb passed");
    else
      $display("tween_slot_engine_with_easing_tb failed");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tween_slot_engine_with_easing_tb failed");
    $finish;
  end
endmodule
